[src/rss_pkg.sv]
package rss_pkg;

  localparam int DEFAULT_COUNT_WIDTH = 24;
  localparam int SAMPLE_WIDTH        = 16;
  localparam int SEEN_WIDTH          = 24;
  localparam int VAR_WIDTH           = 31;
  localparam int CREST_WIDTH         = 24;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef struct packed {
    op_t                             op;
    logic signed [SAMPLE_WIDTH-1:0]  sample;
  } item_t;

  // last field in the low bits
  typedef struct packed {
    logic [CREST_WIDTH-1:0]          crest_factor;
    logic [SAMPLE_WIDTH-1:0]         peak;
    logic [SAMPLE_WIDTH-1:0]         rms;
    logic [VAR_WIDTH-1:0]            variance;
    logic signed [SAMPLE_WIDTH-1:0]  mean;
    logic signed [SAMPLE_WIDTH-1:0]  maximum;
    logic signed [SAMPLE_WIDTH-1:0]  minimum;
    logic [SEEN_WIDTH-1:0]           samples_seen;
  } result_t;

endpackage

[src/running_sample_statistics.sv]
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: sample; tuser: opcode
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: the eight statistics
//
// One word at a time goes through the back end. Each push runs the shared
// one-bit-per-cycle divider for up to five divisions per word; an empty
// result skips the divider. Reset is synchronous and clears all totals.
// A two-word input queue and the output register let either side stall
// without stopping the other.
module running_sample_statistics import rss_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [15:0] sample
  input  logic         s_axis_tuser,   // [0] opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [23:0] samples_seen, [39:24] minimum, [55:40] maximum, [71:56] mean,
  // [102:72] variance, [118:103] rms, [134:119] peak, [158:135] crest_factor
  output logic [159:0] m_axis_tdata
);

  logic    item_valid;
  logic    item_ready;
  item_t   item;
  result_t res;

  rss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_op      (s_axis_tuser),
    .in_sample  (s_axis_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  rss_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  assign m_axis_tdata = {1'b0, res};

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.samples_seen == '0 && COUNT_WIDTH <= SEEN_WIDTH)
      |-> (res.minimum == '0 && res.maximum == '0 && res.variance == '0 &&
           res.rms == '0 && res.peak == '0 && res.crest_factor == '0))
    else $error("nonzero statistics on empty result");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.minimum <= res.maximum))
    else $error("minimum above maximum");

  a_crest_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && res.rms == '0) |-> (res.crest_factor == '0))
    else $error("crest factor with zero rms");

  a_rms_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (res.rms <= res.peak))
    else $error("rms above peak");

endmodule

[src/rss_front.sv]
module rss_front import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_sample,
  output logic        item_valid,
  input  logic        item_ready,
  output item_t       item
);

  // two-entry queue between the stream port and the arithmetic back end
  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;
  item_t       incoming;

  always_comb begin
    incoming.op     = in_op ? OP_CLEAR : OP_PUSH;
    incoming.sample = in_sample;
  end

  assign in_ready   = (fill != 2'd2);
  assign item_valid = (fill != 2'd0);
  assign item       = slots[rd_ptr];
  assign push       = in_valid && in_ready;
  assign pop        = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[src/rss_div.sv]
module rss_div #(
  parameter int N = 54,
  parameter int D = 24
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [N-1:0] dividend,
  input  logic [D-1:0] divisor,
  output logic         done,
  output logic [N-1:0] quotient,
  output logic [D-1:0] remainder
);

  localparam int CW = $clog2(N + 1);

  // restoring divider, one quotient bit per cycle
  logic [D-1:0]  rem;
  logic [N-1:0]  quo;
  logic [D-1:0]  dvs;
  logic [CW-1:0] left;
  logic          run;
  logic [D:0]    trial;
  logic          fits;

  assign trial     = {rem, quo[N-1]};
  assign fits      = trial >= {1'b0, dvs};
  assign quotient  = quo;
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        left <= CW'(N);
      end else if (run) begin
        rem  <= fits ? D'(trial - {1'b0, dvs}) : trial[D-1:0];
        quo  <= {quo[N-2:0], fits};
        left <= left - CW'(1);
        if (left == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[src/rss_back.sv]
module rss_back import rss_pkg::*; #(
  parameter int COUNT_WIDTH = DEFAULT_COUNT_WIDTH
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  localparam int CNW = COUNT_WIDTH;
  localparam int SW  = CNW + 16;
  localparam int QW  = CNW + 30;
  localparam int W   = (2 * CNW > QW) ? 2 * CNW : QW;
  localparam int DW  = (CNW > 16) ? CNW : 16;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_DMEAN, S_MRSQ, S_DRSQ, S_MSUB, S_DVAR, S_DMS,
    S_SQRT, S_DCREST, S_OUT
  } state_t;

  state_t                  state;
  logic [CNW-1:0]          cnt;
  logic signed [SW-1:0]    sum;
  logic [QW-1:0]           sumsq;
  logic signed [15:0]      lo;
  logic signed [15:0]      hi;

  logic [SW-1:0]           mag;
  logic                    neg;
  logic [15:0]             q;
  logic [CNW-1:0]          r;
  logic [W-1:0]            ceil_part;
  logic [W-1:0]            mul_a;
  logic [DW-1:0]           mul_b;
  logic [W-1:0]            acc;
  logic [VAR_WIDTH-1:0]    var_q;
  logic [31:0]             sq_v;
  logic [31:0]             sq_res;
  logic [31:0]             sq_bit;
  logic [15:0]             rms;
  logic [CREST_WIDTH-1:0]  crest;

  logic                    div_start;
  logic [W-1:0]            div_a;
  logic [DW-1:0]           div_b;
  logic                    div_done;
  logic [W-1:0]            div_q;
  logic [DW-1:0]           div_r;

  logic [31:0]             sq_try;
  logic [15:0]             pk;
  logic [W-1:0]            sub;
  logic [W-1:0]            m_val;
  logic [16:0]             abs_lo;
  logic [16:0]             abs_hi;
  logic [31:0]             s_sq;
  logic [W-1:0]            cnt_w;

  rss_div #(.N(W), .D(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  always_comb begin
    abs_lo = lo[15] ? 17'(-{lo[15], lo}) : {1'b0, lo};
    abs_hi = hi[15] ? 17'(-{hi[15], hi}) : {1'b0, hi};
    pk     = (abs_hi > abs_lo) ? abs_hi[15:0] : abs_lo[15:0];
    sq_try = sq_res + sq_bit;
    sub    = acc + ceil_part;
    m_val  = (W'(sumsq) >= sub) ? W'(sumsq) - sub : '0;
    s_sq   = 32'(item.sample * item.sample);
    cnt_w  = W'(cnt);
  end

  assign item_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      sum       <= '0;
      sumsq     <= '0;
      lo        <= '0;
      hi        <= '0;
      res_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      // start is a one-cycle pulse; no state issues a division while it is high
      if (div_start) div_start <= 1'b0;
      if (res_valid && res_ready && state != S_OUT) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (item.op == OP_CLEAR) begin
              cnt   <= '0;
              sum   <= '0;
              sumsq <= '0;
              lo    <= '0;
              hi    <= '0;
            end else if (cnt != {CNW{1'b1}}) begin
              if (cnt == '0) begin
                lo <= item.sample;
                hi <= item.sample;
              end else begin
                if (item.sample < lo) lo <= item.sample;
                if (item.sample > hi) hi <= item.sample;
              end
              sum   <= sum + SW'(item.sample);
              sumsq <= sumsq + QW'(s_sq);
              cnt   <= cnt + CNW'(1);
            end
            state <= S_START;
          end
        end
        S_START: begin
          neg <= sum[SW-1];
          mag <= sum[SW-1] ? SW'(-sum) : SW'(sum);
          if (cnt == '0) begin
            var_q <= '0;
            rms   <= '0;
            crest <= '0;
            q     <= '0;
            state <= S_OUT;
          end else begin
            div_a     <= sum[SW-1] ? W'(SW'(-sum)) : W'(SW'(sum));
            div_b     <= DW'(cnt);
            div_start <= 1'b1;
            state     <= S_DMEAN;
          end
        end
        S_DMEAN: begin
          if (div_done) begin
            q     <= div_q[15:0];
            r     <= div_r[CNW-1:0];
            mul_a <= W'(div_r[CNW-1:0]);
            mul_b <= DW'(div_r[CNW-1:0]);
            acc   <= '0;
            state <= S_MRSQ;
          end
        end
        // shift-add multiply, runs until the multiplier is exhausted
        S_MRSQ, S_MSUB: begin
          if (mul_b == '0) begin
            if (state == S_MRSQ) begin
              div_a     <= acc;
              div_b     <= DW'(cnt);
              div_start <= 1'b1;
              state     <= S_DRSQ;
            end else begin
              div_a     <= m_val;
              div_b     <= DW'(cnt);
              div_start <= 1'b1;
              state     <= S_DVAR;
            end
          end else begin
            if (mul_b[0]) acc <= acc + mul_a;
            mul_a <= {mul_a[W-2:0], 1'b0};
            mul_b <= mul_b >> 1;
          end
        end
        S_DRSQ: begin
          if (div_done) begin
            ceil_part <= div_q + W'(div_r != '0);
            // q*c + 2r = mag + r
            mul_a     <= W'(mag) + W'(r);
            mul_b     <= DW'(q);
            acc       <= '0;
            state     <= S_MSUB;
          end
        end
        S_DVAR: begin
          if (div_done) begin
            var_q     <= div_q[VAR_WIDTH-1:0];
            div_a     <= W'(sumsq);
            div_b     <= DW'(cnt);
            div_start <= 1'b1;
            state     <= S_DMS;
          end
        end
        S_DMS: begin
          if (div_done) begin
            sq_v   <= div_q[31:0];
            sq_res <= '0;
            sq_bit <= 32'h4000_0000;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sq_bit == '0) begin
            rms <= sq_res[15:0];
            if (sq_res == '0) begin
              crest <= '0;
              state <= S_OUT;
            end else begin
              div_a     <= W'({pk, 8'd0});
              div_b     <= DW'(sq_res[15:0]);
              div_start <= 1'b1;
              state     <= S_DCREST;
            end
          end else begin
            if (sq_v >= sq_try) begin
              sq_v   <= sq_v - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end
        S_DCREST: begin
          if (div_done) begin
            crest <= div_q[CREST_WIDTH-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid        <= 1'b1;
            res.samples_seen <= cnt_w[SEEN_WIDTH-1:0];
            res.minimum      <= lo;
            res.maximum      <= hi;
            res.mean         <= neg ? -q : q;
            res.variance     <= var_q;
            res.rms          <= rms;
            res.peak         <= (cnt == '0) ? 16'd0 : pk;
            res.crest_factor <= crest;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[verif/running_sample_statistics_tb.sv]
`timescale 1ns / 100ps

module running_sample_statistics_tb;
  import rss_pkg::*;

  localparam int CW = 24;
  localparam longint unsigned COUNT_MAX = (64'd1 << CW) - 1;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;

  running_sample_statistics #(.COUNT_WIDTH(CW)) DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #1 clk = ~clk;

  // predictor state
  longint unsigned acc_count;
  longint          acc_sum;
  longint unsigned acc_sumsq;
  int              acc_low, acc_high;

  result_t stats_queue[$];
  int      error_count = 0;
  int      burst_left = 0;

  function automatic longint unsigned isqrt64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag32(int v);
    return v < 0 ? longint'(-longint'(v)) : longint'(v);
  endfunction

  function automatic result_t update_stats(op_t op, logic signed [15:0] smp);
    result_t r;
    longint unsigned c, mag, q, rem, rsq, ceil_part, sub, m, rms, pk;
    int s;
    s = smp;
    if (op == OP_CLEAR) begin
      acc_count = 0; acc_sum = 0; acc_sumsq = 0; acc_low = 0; acc_high = 0;
    end else if (acc_count < COUNT_MAX) begin
      if (acc_count == 0) begin
        acc_low = s; acc_high = s;
      end else begin
        if (s < acc_low) acc_low = s;
        if (s > acc_high) acc_high = s;
      end
      acc_sum += s;
      acc_sumsq += longint'(s) * longint'(s);
      acc_count++;
    end
    r = '0;
    c = acc_count;
    if (c == 0) return r;
    mag = acc_sum < 0 ? -acc_sum : acc_sum;
    q = mag / c;
    rem = mag % c;
    rsq = rem * rem;
    ceil_part = rsq / c + ((rsq % c) != 0 ? 1 : 0);
    sub = q * q * c + 2 * q * rem + ceil_part;
    m = acc_sumsq >= sub ? acc_sumsq - sub : 0;
    rms = isqrt64(acc_sumsq / c);
    pk = mag32(acc_low);
    if (mag32(acc_high) > pk) pk = mag32(acc_high);
    r.samples_seen = c[23:0];
    r.minimum      = acc_low[15:0];
    r.maximum      = acc_high[15:0];
    r.mean         = acc_sum < 0 ? 16'(-q) : 16'(q);
    r.variance     = 31'(m / c);
    r.rms          = rms[15:0];
    r.peak         = pk[15:0];
    r.crest_factor = rms != 0 ? 24'((pk * 256) / rms) : '0;
    return r;
  endfunction

  task automatic send_word(op_t op, logic signed [15:0] smp);
    int gap;
    // sender bursts with random gaps; valid stays high inside a burst
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 40) : 0;
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'($urandom);
      end
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= smp;
    do @(posedge clk); while (!s_axis_tready);
    stats_queue.push_back(update_stats(op, smp));
    @(negedge clk);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 16'($urandom);
    do @(negedge clk); while (stats_queue.size() != 0);
  endtask

  task automatic test_directed;
    send_word(OP_PUSH, 16'sd5);          // result from empty state after reset
    send_word(OP_CLEAR, 16'sd0);
    send_word(OP_CLEAR, 16'sh7FFF);      // clear while empty
    send_word(OP_PUSH, -16'sd32768);     // first sample sets min and max
    send_word(OP_PUSH, 16'sd32767);
    send_word(OP_PUSH, 16'sd0);
    send_word(OP_PUSH, -16'sd1);
    send_word(OP_CLEAR, 16'shFFFF);
    send_word(OP_PUSH, 16'sd0);          // zero rms
    send_word(OP_PUSH, 16'sd0);
    send_word(OP_PUSH, 16'sd1);
    send_word(OP_CLEAR, 16'sd0);
    repeat (6) send_word(OP_PUSH, -16'sd32768);
    send_word(OP_PUSH, 16'sd3);
    send_word(OP_PUSH, -16'sd3);
    send_word(OP_CLEAR, 16'sd0);
    send_word(OP_PUSH, 16'sd7);
    send_word(OP_PUSH, -16'sd2);
    drain();
  endtask

  task automatic test_random;
    logic signed [15:0] smp;
    int mode;
    for (int i = 0; i < 600; i++) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0:       smp = $urandom_range(0, 1) ? 16'sh7FFF : -16'sd32768;
        1, 2:    smp = 16'($signed($urandom_range(0, 40)) - 20);
        default: smp = 16'($urandom);
      endcase
      send_word($urandom_range(0, 39) == 0 ? OP_CLEAR : OP_PUSH, smp);
    end
    drain();
  endtask

  // receiver stalls on its own pattern
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(0, 7) < 5) || ($time / 4000) % 2 == 1;
  end

  always @(posedge clk) begin
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[158:0];
      if (stats_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        error_count++;
      end else begin
        want = stats_queue.pop_front();
        if (got !== want || m_axis_tdata[159] !== 1'b0) begin
          $display("%0t: mismatch seen exp %0d act %0d, min exp %0d act %0d, max exp %0d act %0d",
                   $time, want.samples_seen, got.samples_seen, want.minimum, got.minimum,
                   want.maximum, got.maximum);
          $display("  mean exp %0d act %0d, var exp %0d act %0d, rms exp %0d act %0d",
                   want.mean, got.mean, want.variance, got.variance, want.rms, got.rms);
          $display("  peak exp %0d act %0d, crest exp %0d act %0d, pad bit act %b",
                   want.peak, got.peak, want.crest_factor, got.crest_factor, m_axis_tdata[159]);
          error_count++;
        end
      end
    end
  end

  initial begin
    acc_count = 0; acc_sum = 0; acc_sumsq = 0; acc_low = 0; acc_high = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    repeat (1000) @(negedge clk);
    if (error_count == 0 && stats_queue.size() == 0) begin
      $display("running_sample_statistics_tb: PASS");
    end else begin
      $display("running_sample_statistics_tb: FAIL");
    end
    $finish;
  end

  // ~650 words plus stalls, with wide margin
  initial begin
    #3000000;
    $display("running_sample_statistics_tb: FAIL");
    $finish;
  end

endmodule
